>>> rtl/core/modular_exponentiation_core_assert.svh
// Assertion macros used by the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define MODEXP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/modexp_pkg.sv
// Shared widths, types, codes and microcode program of the modular exponentiation core
`default_nettype none

package modexp_pkg;

    // Operand widths
    localparam int MOD_WIDTH = 32;
    localparam int BASE_W    = 63;
    localparam int EXP_W     = 63;
    localparam int MODIN_W   = 32;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = 2 * MOD_WIDTH;

    // Reduction unit: dividend width and two dividend bits per cycle
    localparam int RED_W     = 64;
    localparam int RED_STEPS = RED_W / 2;
    localparam int CNT_W     = $clog2(RED_STEPS);

    typedef logic [MOD_WIDTH-1:0] mod_word_t;
    typedef logic [MOD_WIDTH:0]   mod_wide_t;
    typedef logic [PROD_W-1:0]    prod_word_t;
    typedef logic [RED_W-1:0]     red_word_t;
    typedef logic [OUT_W-1:0]     out_word_t;

    // Microcode fields
    localparam int PC_W   = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 3;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_INIT      = 4'd2;
    localparam logic [OP_W-1:0] OP_RED_BASE  = 4'd3;
    localparam logic [OP_W-1:0] OP_WAIT_SQ   = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_AS    = 4'd5;
    localparam logic [OP_W-1:0] OP_RED_PROD  = 4'd6;
    localparam logic [OP_W-1:0] OP_WAIT_ACC  = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_SS    = 4'd8;
    localparam logic [OP_W-1:0] OP_WAIT_SQSH = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT       = 4'd10;

    // Jump conditions: jump to target when true, else fall through
    localparam logic [COND_W-1:0] COND_NEXT     = 3'd0;
    localparam logic [COND_W-1:0] COND_JUMP     = 3'd1;
    localparam logic [COND_W-1:0] COND_NO_INPUT = 3'd2;
    localparam logic [COND_W-1:0] COND_RED_BUSY = 3'd3;
    localparam logic [COND_W-1:0] COND_EXP_ZERO = 3'd4;
    localparam logic [COND_W-1:0] COND_EXP_EVEN = 3'd5;
    localparam logic [COND_W-1:0] COND_MOD_ZERO = 3'd6;
    localparam logic [COND_W-1:0] COND_OUT_FULL = 3'd7;

    // Program addresses
    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] STEP_INIT     = 4'd1;
    localparam logic [PC_W-1:0] STEP_RED_BASE = 4'd2;
    localparam logic [PC_W-1:0] STEP_WAIT_SQ  = 4'd3;
    localparam logic [PC_W-1:0] STEP_TEST     = 4'd4;
    localparam logic [PC_W-1:0] STEP_MUL_AS   = 4'd5;
    localparam logic [PC_W-1:0] STEP_RED_AS   = 4'd6;
    localparam logic [PC_W-1:0] STEP_WAIT_ACC = 4'd7;
    localparam logic [PC_W-1:0] STEP_SQUARE   = 4'd8;
    localparam logic [PC_W-1:0] STEP_RED_SS   = 4'd9;
    localparam logic [PC_W-1:0] STEP_WAIT_SS  = 4'd10;
    localparam logic [PC_W-1:0] STEP_LOOP     = 4'd11;
    localparam logic [PC_W-1:0] STEP_OUT      = 4'd12;
    localparam logic [PC_W-1:0] STEP_RETURN   = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctrl_word_t;

    // Control store: one control word per program step
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: COND_JUMP, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:     w = '{op: OP_LOAD,      cond: COND_NO_INPUT, target: STEP_IDLE};
            STEP_INIT:     w = '{op: OP_INIT,      cond: COND_MOD_ZERO, target: STEP_OUT};
            STEP_RED_BASE: w = '{op: OP_RED_BASE,  cond: COND_NEXT,     target: STEP_IDLE};
            STEP_WAIT_SQ:  w = '{op: OP_WAIT_SQ,   cond: COND_RED_BUSY, target: STEP_WAIT_SQ};
            STEP_TEST:     w = '{op: OP_NOP,       cond: COND_EXP_ZERO, target: STEP_OUT};
            STEP_MUL_AS:   w = '{op: OP_MUL_AS,    cond: COND_EXP_EVEN, target: STEP_SQUARE};
            STEP_RED_AS:   w = '{op: OP_RED_PROD,  cond: COND_NEXT,     target: STEP_IDLE};
            STEP_WAIT_ACC: w = '{op: OP_WAIT_ACC,  cond: COND_RED_BUSY, target: STEP_WAIT_ACC};
            STEP_SQUARE:   w = '{op: OP_MUL_SS,    cond: COND_NEXT,     target: STEP_IDLE};
            STEP_RED_SS:   w = '{op: OP_RED_PROD,  cond: COND_NEXT,     target: STEP_IDLE};
            STEP_WAIT_SS:  w = '{op: OP_WAIT_SQSH, cond: COND_RED_BUSY, target: STEP_WAIT_SS};
            STEP_LOOP:     w = '{op: OP_NOP,       cond: COND_JUMP,     target: STEP_TEST};
            STEP_OUT:      w = '{op: OP_OUT,       cond: COND_OUT_FULL, target: STEP_OUT};
            STEP_RETURN:   w = '{op: OP_NOP,       cond: COND_JUMP,     target: STEP_IDLE};
            default:       w = '{op: OP_NOP,       cond: COND_JUMP,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/modexp_reduce.sv
// Multi-cycle reduction unit: restoring remainder, two dividend bits per cycle
`default_nettype none

module modexp_reduce (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire modexp_pkg::red_word_t dividend,
    input  wire modexp_pkg::mod_word_t modulus,
    output logic                       busy,
    output modexp_pkg::mod_word_t      remainder
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [modexp_pkg::CNT_W-1:0]  cnt_reg;
    logic [modexp_pkg::CNT_W-1:0]  cnt_next;
    modexp_pkg::red_word_t         div_reg;
    modexp_pkg::red_word_t         div_next;
    modexp_pkg::mod_word_t         rem_reg;
    modexp_pkg::mod_word_t         rem_next;
    modexp_pkg::mod_wide_t         part1;
    modexp_pkg::mod_wide_t         part2;
    modexp_pkg::mod_wide_t         mod_wide;

    assign mod_wide = modexp_pkg::mod_wide_t'(modulus);

    // Shift in the two top dividend bits, subtract the modulus where it fits
    always_comb
    begin
        part1 = {rem_reg, div_reg[modexp_pkg::RED_W-1]};
        if (part1 >= mod_wide)
        begin
            part1 = part1 - mod_wide;
        end
        part2 = {part1[modexp_pkg::MOD_WIDTH-1:0], div_reg[modexp_pkg::RED_W-2]};
        if (part2 >= mod_wide)
        begin
            part2 = part2 - mod_wide;
        end
    end

    // Load on start, advance two bits per cycle, drop busy after the last pair
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = modexp_pkg::CNT_W'(modexp_pkg::RED_STEPS - 1);
            div_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = part2[modexp_pkg::MOD_WIDTH-1:0];
            div_next = div_reg << 2;
            cnt_next = cnt_reg - modexp_pkg::CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/modular_exponentiation_core.sv
// Top level: microcoded square-and-multiply modular exponentiation
//
//   channel  direction  handshake            payload
//   in       into core  in_valid / in_stall  base_value, exponent_value, modulus_value
//   out      from core  out_valid / out_stall power_residue
//
// One item at a time. Base reduction and every exponent bit up to the highest set one
// run through the shared two-bit-per-cycle reduction unit: a clear bit takes one
// reduction (the square), a set bit two (multiply, then square), so this unit sets the
// time from one transfer in to the next, for exponents up to 63 bits.
// Reset returns the sequencer to its idle step and empties the output register.
// A result waiting under out_stall does not block the next transfer in.
`default_nettype none

module modular_exponentiation_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [modexp_pkg::BASE_W-1:0] base_value,
    input  wire logic [modexp_pkg::EXP_W-1:0]  exponent_value,
    input  wire logic [modexp_pkg::MODIN_W-1:0] modulus_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [modexp_pkg::OUT_W-1:0]       power_residue
);

`include "modular_exponentiation_core_assert.svh"

    localparam modexp_pkg::mod_word_t MOD_ONE = modexp_pkg::mod_word_t'(1);

    logic [modexp_pkg::PC_W-1:0]   pc_reg;
    logic [modexp_pkg::PC_W-1:0]   pc_next;
    modexp_pkg::ctrl_word_t        ctrl;
    logic                          take_jump;
    logic                          in_xfer;
    logic                          out_full;
    logic                          out_write;

    logic [modexp_pkg::BASE_W-1:0] base_reg;
    logic [modexp_pkg::EXP_W-1:0]  exp_reg;
    logic [modexp_pkg::EXP_W-1:0]  exp_next;
    modexp_pkg::mod_word_t         mod_reg;
    modexp_pkg::mod_word_t         acc_reg;
    modexp_pkg::mod_word_t         acc_next;
    modexp_pkg::mod_word_t         sq_reg;
    modexp_pkg::mod_word_t         sq_next;
    modexp_pkg::prod_word_t        prod_reg;
    modexp_pkg::prod_word_t        prod_next;
    modexp_pkg::out_word_t         result_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic                          red_start;
    modexp_pkg::red_word_t         red_dividend;
    logic                          red_busy;
    modexp_pkg::mod_word_t         red_rem;

    logic                          sq_done;
    logic                          result_check;

    // Fetch the control word of the current step
    assign ctrl      = modexp_pkg::ucode_rom(pc_reg);
    assign in_stall  = (pc_reg != modexp_pkg::STEP_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_full  = out_valid_reg && out_stall;
    assign out_write = (ctrl.op == modexp_pkg::OP_OUT) && !out_full;

    // Evaluate the jump condition
    always_comb
    begin
        case (ctrl.cond)
            modexp_pkg::COND_NEXT:     take_jump = 1'b0;
            modexp_pkg::COND_JUMP:     take_jump = 1'b1;
            modexp_pkg::COND_NO_INPUT: take_jump = !in_valid;
            modexp_pkg::COND_RED_BUSY: take_jump = red_busy;
            modexp_pkg::COND_EXP_ZERO: take_jump = (exp_reg == '0);
            modexp_pkg::COND_EXP_EVEN: take_jump = !exp_reg[0];
            modexp_pkg::COND_MOD_ZERO: take_jump = (mod_reg == '0);
            modexp_pkg::COND_OUT_FULL: take_jump = out_full;
            default:                   take_jump = 1'b1;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + modexp_pkg::PC_W'(1);
    end

    // Start the reduction unit on the base or on the registered product
    assign red_start    = (ctrl.op == modexp_pkg::OP_RED_BASE) ||
                          (ctrl.op == modexp_pkg::OP_RED_PROD);
    assign red_dividend = (ctrl.op == modexp_pkg::OP_RED_BASE) ?
                          modexp_pkg::red_word_t'(base_reg) :
                          modexp_pkg::red_word_t'(prod_reg);

    modexp_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (red_start),
        .dividend  (red_dividend),
        .modulus   (mod_reg),
        .busy      (red_busy),
        .remainder (red_rem)
    );

    // Datapath actions selected by the control word
    always_comb
    begin
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        prod_next = prod_reg;
        case (ctrl.op)
            modexp_pkg::OP_INIT:
            begin
                acc_next = (mod_reg > MOD_ONE) ? MOD_ONE : '0;
            end
            modexp_pkg::OP_WAIT_SQ:
            begin
                if (!red_busy)
                begin
                    sq_next = red_rem;
                end
            end
            modexp_pkg::OP_MUL_AS:
            begin
                prod_next = modexp_pkg::prod_word_t'(acc_reg) *
                            modexp_pkg::prod_word_t'(sq_reg);
            end
            modexp_pkg::OP_WAIT_ACC:
            begin
                if (!red_busy)
                begin
                    acc_next = red_rem;
                end
            end
            modexp_pkg::OP_MUL_SS:
            begin
                prod_next = modexp_pkg::prod_word_t'(sq_reg) *
                            modexp_pkg::prod_word_t'(sq_reg);
            end
            modexp_pkg::OP_WAIT_SQSH:
            begin
                if (!red_busy)
                begin
                    sq_next  = red_rem;
                    exp_next = exp_reg >> 1;
                end
            end
            default:
            begin
                exp_next = exp_reg;
            end
        endcase
    end

    // Output register: fill on write, drop on transfer out
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= modexp_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operand, working and result registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            base_reg <= base_value;
            exp_reg  <= exponent_value;
            mod_reg  <= modexp_pkg::mod_word_t'(modulus_value);
        end
        else
        begin
            exp_reg <= exp_next;
        end
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        prod_reg <= prod_next;
        if (out_write)
        begin
            result_reg <= modexp_pkg::out_word_t'(acc_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign power_residue = result_reg;

    // Qualify the range checks
    assign sq_done      = (ctrl.op == modexp_pkg::OP_WAIT_SQSH) && !red_busy;
    assign result_check = out_write && (mod_reg != '0);

    // Checks on sequencing and residue range
    `MODEXP_ASSERT_IMPL(a_no_restart, red_start, !red_busy, "reduction started while busy")
    `MODEXP_ASSERT_NEXT(a_red_runs, red_start, red_busy, "reduction did not start")
    `MODEXP_ASSERT_IMPL(a_idle_on_load, in_xfer, !red_busy, "transfer in during reduction")
    `MODEXP_ASSERT_IMPL(a_rem_range, sq_done, red_rem < mod_reg, "remainder not below modulus")
    `MODEXP_ASSERT_IMPL(a_result_range, result_check, acc_reg < mod_reg, "result out of range")

endmodule

`default_nettype wire

>>> tb/sv/modular_exponentiation_core_tb.sv
// Self-checking testbench for the square-and-multiply modular exponentiation core
module modular_exponentiation_core_tb;

    localparam int TAIL_ITEMS     = 15;
    localparam int RANDOM_ITEMS   = 111;
    localparam int HOLD_CYCLES    = 12000;
    localparam int HOLD_AFTER     = 30;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TIMEOUT_UNITS  = 8000000;

    localparam logic [modexp_pkg::BASE_W-1:0]  BASE_MAX = '1;
    localparam logic [modexp_pkg::EXP_W-1:0]   EXP_MAX  = '1;
    localparam logic [modexp_pkg::MODIN_W-1:0] MOD_MAX  = '1;

    typedef struct {
        logic [modexp_pkg::BASE_W-1:0]  base;
        logic [modexp_pkg::EXP_W-1:0]   exponent;
        logic [modexp_pkg::MODIN_W-1:0] modulus;
        modexp_pkg::out_word_t          residue;
    } modexp_job_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                               in_valid       = 1'b0;
    logic                               in_stall;
    logic [modexp_pkg::BASE_W-1:0]      base_value     = '0;
    logic [modexp_pkg::EXP_W-1:0]       exponent_value = '0;
    logic [modexp_pkg::MODIN_W-1:0]     modulus_value  = '0;
    logic                               out_valid;
    logic                               out_stall      = 1'b0;
    modexp_pkg::out_word_t              power_residue;

    modexp_job_t operand_queue[$];
    modexp_job_t residue_queue[$];
    modexp_job_t driven_job;
    modexp_job_t oldest_job;

    int send_gap     = 0;
    int stall_left   = 0;
    int error_count  = 0;
    int results_seen = 0;
    int jobs_total   = 0;
    logic tail_phase = 1'b0;
    logic hold_off   = 1'b0;

    modular_exponentiation_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .modulus_value  (modulus_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .power_residue  (power_residue)
    );

    // Right-to-left square-and-multiply with 64-bit products
    function automatic modexp_pkg::out_word_t power_mod(
        input logic [modexp_pkg::BASE_W-1:0]  b,
        input logic [modexp_pkg::EXP_W-1:0]   e,
        input logic [modexp_pkg::MODIN_W-1:0] m_in);
        logic [63:0]                  m;
        logic [63:0]                  acc;
        logic [63:0]                  sq;
        logic [modexp_pkg::EXP_W-1:0] rest;
        m = 64'(m_in) & ((64'd1 << modexp_pkg::MOD_WIDTH) - 64'd1);
        if (m == 64'd0)
            return '0;
        acc  = 64'd1 % m;
        sq   = 64'(b) % m;
        rest = e;
        while (rest != '0)
        begin
            if (rest[0])
                acc = (acc * sq) % m;
            sq   = (sq * sq) % m;
            rest = rest >> 1;
        end
        return acc[modexp_pkg::OUT_W-1:0];
    endfunction

    // Random value of the given bit length
    function automatic logic [63:0] rand_bits(input int nbits);
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        if (nbits < 64)
            r = r & ((64'd1 << nbits) - 64'd1);
        return r;
    endfunction

    task automatic add_job(input logic [modexp_pkg::BASE_W-1:0] b,
                           input logic [modexp_pkg::EXP_W-1:0] e,
                           input logic [modexp_pkg::MODIN_W-1:0] m);
        modexp_job_t job;
        job.base     = b;
        job.exponent = e;
        job.modulus  = m;
        job.residue  = '0;
        operand_queue = {operand_queue, job};
        jobs_total++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive operands; predict the residue of each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            tail_phase <= 1'b0;
            send_gap   = 0;
        end
        else
        begin
            tail_phase <= (operand_queue.size() < TAIL_ITEMS);
            if (!(in_valid && in_stall))
            begin
                if (in_valid)
                begin
                    driven_job.residue = power_mod(driven_job.base, driven_job.exponent,
                                                   driven_job.modulus);
                    residue_queue = {residue_queue, driven_job};
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!tail_phase && $urandom_range(0, 3) == 0)
                begin
                    send_gap = $urandom_range(0, 18);
                    in_valid <= 1'b0;
                end
                else if (operand_queue.size() != 0)
                begin
                    driven_job = operand_queue.pop_front();
                    base_value     <= driven_job.base;
                    exponent_value <= driven_job.exponent;
                    modulus_value  <= driven_job.modulus;
                    in_valid       <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check each result transfer; choose the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (residue_queue.size() == 0)
                    report_mismatch($sformatf("residue %0h with nothing outstanding",
                                              power_residue));
                else
                begin
                    oldest_job = residue_queue.pop_front();
                    if (power_residue !== oldest_job.residue)
                        report_mismatch($sformatf("%0h ^ %0h mod %0h: got %0h, want %0h",
                                                  oldest_job.base, oldest_job.exponent,
                                                  oldest_job.modulus, power_residue,
                                                  oldest_job.residue));
                end
            end
            if (hold_off)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Hold off the result side long enough for the core to back up its input
    initial
    begin
        while (results_seen < HOLD_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stimulus, reset and end of run
    initial
    begin
        // Directed: extremes and special cases
        add_job('0, '0, 32'd1);
        add_job(BASE_MAX, EXP_MAX, 32'd1);
        add_job('0, '0, 32'd5);
        add_job(BASE_MAX, '0, MOD_MAX);
        add_job('0, 63'd5, 32'd7);
        add_job('0, '0, 32'd0);
        add_job(63'd123, 63'd45, 32'd0);
        add_job(BASE_MAX, EXP_MAX, MOD_MAX);
        add_job(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAB);
        add_job(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555);
        add_job(63'd2, 63'd10, 32'd1000);
        add_job(63'd3, 63'd1, 32'd7);
        add_job(63'd7000000007, 63'd9, 32'd7);
        add_job(63'd5, 63'h4000_0000_0000_0000, 32'hFFFF_FFFB);
        add_job(63'd1, EXP_MAX, MOD_MAX);
        add_job(63'hFFFF_FFFE, 63'd2, MOD_MAX);
        add_job(BASE_MAX, 63'd3, 32'd2);
        add_job(63'd10, 63'd20, 32'h8000_0000);
        add_job(63'hFFFF_FFFF, 63'd1, MOD_MAX);

        // Random: mostly short exponents, a few full-length ones
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            logic [modexp_pkg::BASE_W-1:0]  b;
            logic [modexp_pkg::EXP_W-1:0]   e;
            logic [modexp_pkg::MODIN_W-1:0] m;
            int                             pick;
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                b = modexp_pkg::BASE_W'(rand_bits(modexp_pkg::BASE_W));
            else if (pick == 7)
                b = modexp_pkg::BASE_W'($urandom_range(0, 3));
            else
                b = modexp_pkg::BASE_W'($urandom());
            if ($urandom_range(0, 7) == 0)
                e = modexp_pkg::EXP_W'(rand_bits(modexp_pkg::EXP_W));
            else
                e = modexp_pkg::EXP_W'(rand_bits($urandom_range(0, 14)));
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                m = $urandom();
            else if (pick == 6)
                m = $urandom_range(1, 16);
            else if (pick == 7)
                m = MOD_MAX - modexp_pkg::MODIN_W'($urandom_range(0, 15));
            else if (pick == 8)
                m = 32'd1;
            else if ($urandom_range(0, 3) == 0)
                m = '0;
            else
                m = 32'h8000_0000 | $urandom();
            add_job(b, e, m);
        end

        // Release reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for a residue out for every item, then drain
        @(posedge clk);
        while (results_seen < jobs_total)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> modular_exponentiation_core.f
+incdir+rtl/core
rtl/core/modexp_pkg.sv
rtl/core/modexp_reduce.sv
rtl/core/modular_exponentiation_core.sv
tb/sv/modular_exponentiation_core_tb.sv
